[design/nks_pkg.sv]
package nks_pkg;

   // Entity position width and depth of the sorted store
   localparam int COORD_BITS = 16;
   localparam int KEEP_MAX   = 16;

   // Fixed widths of the register and result fields
   localparam int REF_W   = 16;
   localparam int OUT_W   = 16;
   localparam int PAY_W   = 32;
   localparam int KEEP_W  = 5;
   localparam int BASE_W  = 6;
   localparam int SLOT_W  = 7;
   localparam int DROP_W  = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_A_W = 2;

   // Derived arithmetic widths
   localparam int DIFF_W = ((COORD_BITS > REF_W) ? COORD_BITS : REF_W) + 1;
   localparam int MAG_W  = DIFF_W - 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + 1;
   localparam int CNT_W  = $clog2(KEEP_MAX + 1);

   // Request queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int PEND_W = $clog2(QDEPTH + 1);

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_REF_X      = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_REF_Y      = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_KEEP_COUNT = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_BASE_SLOT  = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic                         dead;
      logic [PAY_W-1:0]             payload;
      logic                         last_in;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]       slot_index;
      logic signed [OUT_W-1:0] out_x;
      logic signed [OUT_W-1:0] out_y;
      logic [PAY_W-1:0]        out_payload;
      logic [DROP_W-1:0]       dropped_count;
      logic                    empty_res;
      logic                    last_out;
   } rsp_type;

   typedef struct packed {
      logic signed [REF_W-1:0] ref_x;
      logic signed [REF_W-1:0] ref_y;
      logic [KEEP_W-1:0]       keep_count;
      logic [BASE_W-1:0]       base_slot;
   } cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0]            range_sq;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic [PAY_W-1:0]             payload;
      logic                         dead;
      logic                         last_in;
   } qent_type;

endpackage

[design/nks_front.sv]
module nks_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nks_pkg::req_type req_data,
   input  nks_pkg::cfg_type cfg,
   input  logic             pop,
   output logic             push,
   output nks_pkg::qent_type push_data
);
   import nks_pkg::*;

   logic                     accept;
   logic [PEND_W-1:0]        pending_ff, pending_in;
   logic signed [DIFF_W-1:0] dx, dy;
   logic [MAG_W-1:0]         mag_x, mag_y;

   logic                     a_valid_ff;
   logic [MAG_W-1:0]         a_mag_x_ff, a_mag_y_ff;
   req_type                  a_item_ff;
   logic                     b_valid_ff;
   logic [SQ_W-1:0]          b_sq_x_ff, b_sq_y_ff;
   req_type                  b_item_ff;

   // Hold requests off once every queue place is spoken for
   assign busy   = (pending_ff >= PEND_W'(QDEPTH));
   assign accept = start && !busy;

   always_comb begin
      pending_in = pending_ff;
      if (accept && !pop) begin
         pending_in = pending_ff + PEND_W'(1);
      end else if (!accept && pop) begin
         pending_in = pending_ff - PEND_W'(1);
      end
   end

   // Take the absolute offsets from the reference point
   always_comb begin
      dx    = DIFF_W'(req_data.pos_x) - DIFF_W'(cfg.ref_x);
      dy    = DIFF_W'(req_data.pos_y) - DIFF_W'(cfg.ref_y);
      mag_x = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_y = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
      end
   end

   // Offset stage, then squaring stage
   always_ff @(posedge clock) begin
      a_mag_x_ff <= mag_x;
      a_mag_y_ff <= mag_y;
      a_item_ff  <= req_data;
      b_sq_x_ff  <= a_mag_x_ff * a_mag_x_ff;
      b_sq_y_ff  <= a_mag_y_ff * a_mag_y_ff;
      b_item_ff  <= a_item_ff;
   end

   // Sum the squares into the queue entry
   always_comb begin
      push               = b_valid_ff;
      push_data.range_sq = DIST_W'(b_sq_x_ff) + DIST_W'(b_sq_y_ff);
      push_data.pos_x    = b_item_ff.pos_x;
      push_data.pos_y    = b_item_ff.pos_y;
      push_data.payload  = b_item_ff.payload;
      push_data.dead     = b_item_ff.dead;
      push_data.last_in  = b_item_ff.last_in;
   end

endmodule

[design/nks_queue.sv]
module nks_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nks_pkg::qent_type push_data,
   input  logic              pop,
   output logic              empty,
   output nks_pkg::qent_type head
);
   import nks_pkg::*;

   qent_type          mem [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PEND_W-1:0] count_ff;

   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + PEND_W'(1);
         end else if (!push && pop) begin
            count_ff <= count_ff - PEND_W'(1);
         end
      end
   end

endmodule

[design/nks_back.sv]
module nks_back (
   input  logic              clock,
   input  logic              reset,
   input  nks_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  nks_pkg::qent_type head,
   output logic              pop,
   output logic              rsp_strobe,
   output nks_pkg::rsp_type  rsp_data
);
   import nks_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN  = 2'b01,
      ST_EMIT = 2'b10
   } back_state_type;

   back_state_type              state_ff, state_in;
   logic [DIST_W-1:0]           kept_dist_ff [KEEP_MAX];
   logic [DIST_W-1:0]           kept_dist_in [KEEP_MAX];
   logic [COORD_BITS-1:0]       kept_x_ff    [KEEP_MAX];
   logic [COORD_BITS-1:0]       kept_x_in    [KEEP_MAX];
   logic [COORD_BITS-1:0]       kept_y_ff    [KEEP_MAX];
   logic [COORD_BITS-1:0]       kept_y_in    [KEEP_MAX];
   logic [PAY_W-1:0]            kept_pay_ff  [KEEP_MAX];
   logic [PAY_W-1:0]            kept_pay_in  [KEEP_MAX];
   logic [CNT_W-1:0]            kept_total_ff, kept_total_in;
   logic [DROP_W-1:0]           alive_total_ff, alive_total_in;
   logic [CNT_W-1:0]            rank_ff, rank_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]            cap, eff, excess;
   logic [KEEP_MAX-1:0]         vmask, le;
   logic                        alive, full, ins, emit_last;
   logic [DROP_W:0]             drop_sum;

   assign pop        = (state_ff == ST_RUN) && !q_empty;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Trim to the current limit and find the insertion point
   always_comb begin
      cap    = (32'(cfg.keep_count) > KEEP_MAX) ? CNT_W'(KEEP_MAX) : CNT_W'(cfg.keep_count);
      eff    = (kept_total_ff > cap) ? cap : kept_total_ff;
      excess = kept_total_ff - eff;
      for (int i = 0; i < KEEP_MAX; i++) begin
         vmask[i] = (CNT_W'(i) < eff);
         le[i]    = vmask[i] && (kept_dist_ff[i] <= head.range_sq);
      end
      alive     = pop && !head.dead;
      full      = (eff >= cap);
      ins       = alive && (!full || |(vmask & ~le));
      drop_sum  = (DROP_W + 1)'(alive_total_ff) + (DROP_W + 1)'(excess)
                + (DROP_W + 1)'(alive && full);
      emit_last = (kept_total_ff <= CNT_W'(1));
   end

   // Insert by shifting, or drain the head during emission
   always_comb begin
      state_in       = state_ff;
      kept_total_in  = kept_total_ff;
      alive_total_in = alive_total_ff;
      rank_in        = rank_ff;
      rsp_strobe_in  = 1'b0;
      rsp_data_in    = rsp_data_ff;
      for (int i = 0; i < KEEP_MAX; i++) begin
         kept_dist_in[i] = kept_dist_ff[i];
         kept_x_in[i]    = kept_x_ff[i];
         kept_y_in[i]    = kept_y_ff[i];
         kept_pay_in[i]  = kept_pay_ff[i];
      end
      case (state_ff)
         ST_RUN: begin
            if (pop) begin
               kept_total_in  = eff + CNT_W'(alive && !full);
               alive_total_in = drop_sum[DROP_W] ? '1 : drop_sum[DROP_W-1:0];
               if (ins) begin
                  for (int i = 0; i < KEEP_MAX; i++) begin
                     if (!le[i]) begin
                        if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
                           kept_dist_in[i] = head.range_sq;
                           kept_x_in[i]    = head.pos_x;
                           kept_y_in[i]    = head.pos_y;
                           kept_pay_in[i]  = head.payload;
                        end else begin
                           kept_dist_in[i] = kept_dist_ff[(i == 0) ? 0 : i - 1];
                           kept_x_in[i]    = kept_x_ff[(i == 0) ? 0 : i - 1];
                           kept_y_in[i]    = kept_y_ff[(i == 0) ? 0 : i - 1];
                           kept_pay_in[i]  = kept_pay_ff[(i == 0) ? 0 : i - 1];
                        end
                     end
                  end
               end
               if (head.last_in) begin
                  state_in = ST_EMIT;
                  rank_in  = '0;
               end
            end
         end
         ST_EMIT: begin
            rsp_strobe_in             = 1'b1;
            rsp_data_in.slot_index    = SLOT_W'({1'b0, cfg.base_slot}) + SLOT_W'(rank_ff);
            rsp_data_in.out_x         = OUT_W'(signed'(kept_x_ff[0]));
            rsp_data_in.out_y         = OUT_W'(signed'(kept_y_ff[0]));
            rsp_data_in.out_payload   = kept_pay_ff[0];
            rsp_data_in.dropped_count = alive_total_ff;
            rsp_data_in.empty_res     = (kept_total_ff == '0);
            rsp_data_in.last_out      = emit_last;
            if (kept_total_ff == '0) begin
               rsp_data_in.slot_index  = '0;
               rsp_data_in.out_x       = '0;
               rsp_data_in.out_y       = '0;
               rsp_data_in.out_payload = '0;
            end
            for (int i = 0; i < KEEP_MAX - 1; i++) begin
               kept_dist_in[i] = kept_dist_ff[i + 1];
               kept_x_in[i]    = kept_x_ff[i + 1];
               kept_y_in[i]    = kept_y_ff[i + 1];
               kept_pay_in[i]  = kept_pay_ff[i + 1];
            end
            rank_in = rank_ff + CNT_W'(1);
            if (emit_last) begin
               state_in       = ST_RUN;
               kept_total_in  = '0;
               alive_total_in = '0;
            end else begin
               kept_total_in = kept_total_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         kept_total_ff  <= '0;
         alive_total_ff <= '0;
         rank_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         kept_total_ff  <= kept_total_in;
         alive_total_ff <= alive_total_in;
         rank_ff        <= rank_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // Store and result payload carry no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < KEEP_MAX; i++) begin
         kept_dist_ff[i] <= kept_dist_in[i];
         kept_x_ff[i]    <= kept_x_in[i];
         kept_y_ff[i]    <= kept_y_in[i];
         kept_pay_ff[i]  <= kept_pay_in[i];
      end
   end

endmodule

[design/nearest_k_selector_unit.sv]
// Nearest-K selector. Entities enter one per clock through start/busy; each alive one is
// ranked by squared distance to the reference point and kept, nearest first, in a sorted
// store of up to keep_count entries, at most 16 (ties keep arrival order). A request goes
// through the offset and squaring stages, is summed into the queue, and at the queue head
// is compared against every kept entry at once and shifted into place. After the entry
// marked last_in, the set is emitted at one result per clock, max(kept, 1) results, from
// the result register once the state register has turned to emission; rsp_strobe marks
// each result for exactly one cycle and the receiver cannot hold it off, so it must take
// every result as it appears. During emission the store takes no new requests; a
// four-entry queue absorbs the next set's requests until busy rises. Sustained rate is
// one request per clock between emissions. The user must write registers through csr_we
// only while the block is idle; the block itself does not enforce this.
module nearest_k_selector_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  nks_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output nks_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [nks_pkg::CSR_A_W-1:0]   csr_index,
   input  logic [nks_pkg::CSR_W-1:0]     csr_wdata
);
   import nks_pkg::*;

   cfg_type  cfg_ff;
   logic     pop, push, q_empty;
   qent_type push_data, head;

   // Write the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_x      <= '0;
         cfg_ff.ref_y      <= '0;
         cfg_ff.keep_count <= KEEP_W'(16);
         cfg_ff.base_slot  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REF_X:      cfg_ff.ref_x      <= csr_wdata[REF_W-1:0];
            CSR_REF_Y:      cfg_ff.ref_y      <= csr_wdata[REF_W-1:0];
            CSR_KEEP_COUNT: cfg_ff.keep_count <= csr_wdata[KEEP_W-1:0];
            CSR_BASE_SLOT:  cfg_ff.base_slot  <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   nks_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .pop       (pop),
      .push      (push),
      .push_data (push_data)
   );

   nks_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head)
   );

   nks_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[design/nks_checker.sv]
module nks_checker (
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_strobe,
   input nks_pkg::rsp_type rsp_data
);
   import nks_pkg::*;

   // Reset leaves no result pending and the block ready
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe && !busy)
      else $error("result or busy after reset");

   // An empty result closes its run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.empty_res |-> rsp_data.last_out)
      else $error("empty result without last_out");

   // A run is emitted without gaps
   a_run_solid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_out |=> rsp_strobe)
      else $error("gap inside an emitted run");

   // Slots rise by one, the drop count holds and no result is empty across a run
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_out |=>
         rsp_data.slot_index == $past(rsp_data.slot_index) + SLOT_W'(1)
         && rsp_data.dropped_count == $past(rsp_data.dropped_count)
         && !rsp_data.empty_res)
      else $error("slot or drop count broken inside a run");

endmodule

bind nearest_k_selector_unit nks_checker u_checker (.*);
